### rtl/ima_adpcm_encoder_core_defines.svh
// ============================================================================
// IMA ADPCM encoder assertion macros
// Shared macros for the concurrent checks of the encoder core.
// ============================================================================
`ifndef IMA_ADPCM_ENCODER_CORE_DEFINES_SVH
`define IMA_ADPCM_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ima_pkg.sv
// ============================================================================
// IMA ADPCM package
// Step size table, index adjustment and range constants of the encoder.
// ============================================================================
`timescale 1ns / 1ps

package ima_pkg;

    localparam int unsigned STEP_W  = 15;
    localparam int unsigned INDEX_W = 7;
    localparam int unsigned TABLE_N = 89;

    typedef logic [STEP_W-1:0]  t_step;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [3:0]         t_code;

    localparam t_index MAX_INDEX = 7'd88;

    localparam logic signed [17:0] PCM_MAX = 18'sd32767;
    localparam logic signed [17:0] PCM_MIN = -18'sd32768;

    localparam t_step STEP_TABLE [0:TABLE_N-1] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
        logic signed [7:0] adj;
        case (mag)
            3'd4:    adj = 8'sd2;
            3'd5:    adj = 8'sd4;
            3'd6:    adj = 8'sd6;
            3'd7:    adj = 8'sd8;
            default: adj = -8'sd1;
        endcase
        return adj;
    endfunction

endpackage

### rtl/ima_adpcm_encoder_core.sv
// A byte's second sample is first registered at the input; the byte is then registered onto m_tdata.
// Throughput: one sample per cycle unless an untaken output byte stalls a second sample; one byte every second sample.
// The cycle is set by the state loop: table lookup, three compares with two subtracts, clamp.
// Reset clears the predictor, step index, nibble pairing and both valid flags.
// tuser set on a sample restarts the stream and drops a held low nibble.
// ============================================================================
// IMA ADPCM encoder core
// Encodes 16-bit PCM words into 4-bit IMA ADPCM codes, two codes per byte.
// ============================================================================
`timescale 1ns / 1ps

module ima_adpcm_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] packed_byte
);

    import ima_pkg::*;

    `include "ima_adpcm_encoder_core_defines.svh"

    logic               r_in_valid;
    logic signed [15:0] r_sample;
    logic               r_first;

    logic signed [15:0] r_predictor;
    t_index             r_step_index;
    t_code              r_held_nibble;
    logic               r_odd_phase;

    logic               r_out_valid;
    logic [7:0]         r_out_data;

    logic signed [15:0] eff_pred;
    t_index             eff_idx;
    logic               eff_odd;
    t_code              eff_held;
    t_step              step0;
    t_step              step1;
    t_step              step2;
    logic signed [16:0] diff;
    logic [16:0]        mag0;
    logic [16:0]        mag1;
    logic [16:0]        mag2;
    logic [2:0]         qbits;
    logic [16:0]        delta;
    logic signed [17:0] pred_sum;
    logic signed [15:0] n_predictor;
    logic signed [7:0]  idx_sum;
    t_index             n_step_index;
    t_code              code;
    logic               out_free;
    logic               adv;

    always_comb begin
        eff_pred = r_first ? 16'sd0 : r_predictor;
        eff_idx  = r_first ? '0 : ((r_step_index > MAX_INDEX) ? MAX_INDEX : r_step_index);
        eff_odd  = r_first ? 1'b0 : r_odd_phase;
        eff_held = r_first ? '0 : r_held_nibble;

        step0 = STEP_TABLE[eff_idx];
        step1 = step0 >> 1;
        step2 = step0 >> 2;

        diff = 17'(signed'({r_sample[15], r_sample})) - 17'(signed'({eff_pred[15], eff_pred}));
        mag0 = diff[16] ? 17'(-diff) : 17'(diff);

        qbits[2] = mag0 >= {2'b00, step0};
        mag1     = qbits[2] ? (mag0 - {2'b00, step0}) : mag0;
        qbits[1] = mag1 >= {2'b00, step1};
        mag2     = qbits[1] ? (mag1 - {2'b00, step1}) : mag1;
        qbits[0] = mag2 >= {2'b00, step2};

        delta = {5'b0, step0[STEP_W-1:3]}
              + (qbits[2] ? {2'b00, step0} : 17'd0)
              + (qbits[1] ? {2'b00, step1} : 17'd0)
              + (qbits[0] ? {2'b00, step2} : 17'd0);

        if (diff[16]) begin
            pred_sum = 18'(signed'({{2{eff_pred[15]}}, eff_pred})) - signed'({1'b0, delta});
        end else begin
            pred_sum = 18'(signed'({{2{eff_pred[15]}}, eff_pred})) + signed'({1'b0, delta});
        end

        if (pred_sum > PCM_MAX) begin
            n_predictor = PCM_MAX[15:0];
        end else if (pred_sum < PCM_MIN) begin
            n_predictor = PCM_MIN[15:0];
        end else begin
            n_predictor = pred_sum[15:0];
        end

        idx_sum = signed'({1'b0, eff_idx}) + index_adjust(qbits);
        if (idx_sum < 8'sd0) begin
            n_step_index = '0;
        end else if (idx_sum > signed'({1'b0, MAX_INDEX})) begin
            n_step_index = MAX_INDEX;
        end else begin
            n_step_index = idx_sum[INDEX_W-1:0];
        end

        code = {diff[16], qbits};
    end

    assign out_free = !r_out_valid || m_tready;
    assign adv      = r_in_valid && (!eff_odd || out_free);
    assign s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_sample <= signed'(s_tdata);
            r_first  <= s_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_predictor   <= '0;
            r_step_index  <= '0;
            r_held_nibble <= '0;
            r_odd_phase   <= 1'b0;
        end else if (adv) begin
            r_predictor   <= n_predictor;
            r_step_index  <= n_step_index;
            r_held_nibble <= eff_odd ? t_code'(0) : code;
            r_odd_phase   <= !eff_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && eff_odd) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && eff_odd) begin
            r_out_data <= {code, eff_held};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    `IMA_ASSERT_IMP(a_index_range, 1'b1, r_step_index <= MAX_INDEX,
        "step index left the table range")
    `IMA_ASSERT_NEXT(a_pair_emits, adv && eff_odd, r_out_valid,
        "second code of a pair did not produce a word")
    `IMA_ASSERT_NEXT(a_low_nibble_holds, adv && !eff_odd, r_odd_phase,
        "low nibble did not switch the pairing phase")
    `IMA_ASSERT_IMP(a_no_overwrite, r_out_valid && !m_tready && eff_odd, !adv,
        "pending output word would be overwritten")

endmodule
